### sv/ple_pkg.sv
`default_nettype none

package ple_pkg;

  // payload widths
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned POS_W        = 6;
  localparam int unsigned LEN_OUT_W    = 6;
  localparam int unsigned STAT_W       = 2;
  localparam int unsigned OP_W         = 3;

  // index and length width inside the cell row, wide enough for the largest capacity
  localparam int unsigned CNT_W        = 7;
  localparam int unsigned CAPACITY_DEF = 32;

  // request codes
  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_POS   = 3'd5,
    OP_COUNT     = 3'd6,
    OP_LIST      = 3'd7
  } op_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  // what the cell row does this cycle
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_INSERT,
    CMD_DELETE,
    CMD_ROTATE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] len;
  } cell_cmd_t;

endpackage

`default_nettype wire

### sv/positional_list_engine_top.sv
// the result beat of any request but a non-empty list is registered at the edge that accepts it
// throughput: one insert, delete or count request per cycle while the result side is not stalled; a list
//   request of n elements is accepted, then gives one beat per element from the head cell as the row rotates
// reset: synchronous, active high; clears the element count and the handshake state,
//   cell contents are not cleared and are only read below the count
`default_nettype none

module positional_list_engine_top
  import ple_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     req_valid,
  output logic                          req_ready,
  input  wire logic [OP_W-1:0]          op,
  input  wire logic signed [DATA_W-1:0] value,
  input  wire logic [POS_W-1:0]         position,
  output logic                          rsp_valid,
  input  wire logic                     rsp_ready,
  output logic signed [DATA_W-1:0]      element,
  output logic [LEN_OUT_W-1:0]          length,
  output logic [STAT_W-1:0]             status,
  output logic                          last
);

  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = CNT_W + 1;

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_t;

  state_t                   state;
  logic [LW-1:0]            len;
  logic [LW-1:0]            len_next;
  logic [LW-1:0]            cnt;
  logic [LW-1:0]            cnt_inc;
  status_t                  res_status;
  cell_cmd_t                cmd;
  logic                     room;
  logic                     take;
  logic                     emit;
  logic                     full;
  logic [CW-1:0]            pos_c;
  logic [CW-1:0]            len_c;
  op_t                      op_q;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];

  assign op_q      = op_t'(op);
  assign room      = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) && room;
  assign take      = req_valid && req_ready;
  assign emit      = (state == S_LIST) && room;
  assign full      = (len == LW'(CAPACITY));
  assign pos_c     = CW'(position);
  assign len_c     = CW'(len);
  assign cnt_inc   = cnt + LW'(1);

  // decode the request into a row command, new count and status
  always_comb begin
    cmd.kind   = CMD_NONE;
    cmd.idx    = '0;
    cmd.len    = CNT_W'(len);
    len_next   = len;
    res_status = STAT_OK;
    if (emit) begin
      cmd.kind = CMD_ROTATE;
    end else if (take) begin
      case (op_q)
        OP_INS_FRONT, OP_INS_BACK: begin
          if (full) begin
            res_status = STAT_FULL;
          end else begin
            cmd.kind = CMD_INSERT;
            cmd.idx  = (op_q == OP_INS_FRONT) ? '0 : CNT_W'(len);
            len_next = len + LW'(1);
          end
        end
        OP_INS_POS: begin
          if (pos_c == '0 || pos_c > len_c + CW'(1)) begin
            res_status = STAT_RANGE;
          end else if (full) begin
            res_status = STAT_FULL;
          end else begin
            cmd.kind = CMD_INSERT;
            cmd.idx  = CNT_W'(position) - CNT_W'(1);
            len_next = len + LW'(1);
          end
        end
        OP_DEL_FRONT, OP_DEL_BACK: begin
          if (len == '0) begin
            res_status = STAT_EMPTY;
          end else begin
            cmd.kind = CMD_DELETE;
            cmd.idx  = (op_q == OP_DEL_FRONT) ? '0 : CNT_W'(len) - CNT_W'(1);
            len_next = len - LW'(1);
          end
        end
        OP_DEL_POS: begin
          if (len == '0) begin
            res_status = STAT_EMPTY;
          end else if (pos_c == '0 || pos_c > len_c) begin
            res_status = STAT_RANGE;
          end else begin
            cmd.kind = CMD_DELETE;
            cmd.idx  = CNT_W'(position) - CNT_W'(1);
            len_next = len - LW'(1);
          end
        end
        OP_LIST: begin
          if (len == '0) begin
            res_status = STAT_EMPTY;
          end
        end
        default: begin
          res_status = STAT_OK;
        end
      endcase
    end
  end

  // row of cells, head at index 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_in;
    logic signed [DATA_W-1:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = value;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right_in = cell_data[0];
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end
    ple_cell #(
      .INDEX (i)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .value (value),
      .left  (left_in),
      .right (right_in),
      .head  (cell_data[0]),
      .data  (cell_data[i])
    );
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (emit) begin
        rsp_valid <= 1'b1;
        element   <= cell_data[0];
        length    <= LEN_OUT_W'(len);
        status    <= STAT_OK;
        last      <= (cnt_inc == len);
        cnt       <= cnt_inc;
        if (cnt_inc == len) begin
          state <= S_IDLE;
        end
      end else if (take) begin
        len <= len_next;
        if (op_q == OP_LIST && len != '0) begin
          state <= S_LIST;
          cnt   <= '0;
        end else begin
          rsp_valid <= 1'b1;
          element   <= '0;
          length    <= LEN_OUT_W'(len_next);
          status    <= res_status;
          last      <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### sv/ple_cell.sv
`default_nettype none

module ple_cell
  import ple_pkg::*;
#(
  parameter int unsigned INDEX = 0
) (
  input  wire logic                     clk,
  input  wire cell_cmd_t                cmd,
  input  wire logic signed [DATA_W-1:0] value,
  input  wire logic signed [DATA_W-1:0] left,
  input  wire logic signed [DATA_W-1:0] right,
  input  wire logic signed [DATA_W-1:0] head,
  output logic signed [DATA_W-1:0]      data
);

  localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] NXT = CNT_W'(INDEX + 1);

  logic signed [DATA_W-1:0] data_next;

  // pick this cell's source from the broadcast command
  always_comb begin
    data_next = data;
    case (cmd.kind)
      CMD_INSERT: begin
        if (IDX == cmd.idx) begin
          data_next = value;
        end else if (IDX > cmd.idx && IDX <= cmd.len) begin
          data_next = left;
        end
      end
      CMD_DELETE: begin
        if (IDX >= cmd.idx && NXT < cmd.len) begin
          data_next = right;
        end
      end
      CMD_ROTATE: begin
        if (NXT < cmd.len) begin
          data_next = right;
        end else if (NXT == cmd.len) begin
          data_next = head;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

### sv/ple_checker.sv
`default_nettype none

module ple_checker
  import ple_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     req_ready,
  input wire logic                     rsp_valid,
  input wire logic                     rsp_ready,
  input wire logic signed [DATA_W-1:0] element,
  input wire logic [LEN_OUT_W-1:0]     length,
  input wire logic [STAT_W-1:0]        status,
  input wire logic                     last
);

  // a stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(element) && $stable(status)
      && $stable(length) && $stable(last))
    else $error("result beat changed while stalled");

  // any failure ends its request
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != STAT_OK |-> last)
    else $error("error status on a non-final beat");

  // failures carry no element
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != STAT_OK |-> element == '0)
    else $error("error status with nonzero element");

  // a list run in progress blocks new requests
  a_list_block: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !last |-> !req_ready)
    else $error("request taken during a list run");

  // count never exceeds capacity
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (CAPACITY > 63) || (32'(length) <= CAPACITY))
    else $error("length above capacity");

endmodule

bind positional_list_engine_top ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (.*);

`default_nettype wire

### tb/testbench.sv
`default_nettype none

module testbench
  import ple_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIST_CAP   = CAPACITY_DEF;
  localparam int unsigned ITEM_COUNT = 470;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned DRAIN_CYC  = 20;

  // random phase kinds
  localparam int MODE_GROW   = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIXED  = 2;

  // one expected result beat
  typedef struct {
    logic signed [DATA_W-1:0] element;
    logic [LEN_OUT_W-1:0]     length;
    status_t                  status;
    logic                     last;
  } list_beat_t;

  // list predictor plus queue of result beats still owed by the block
  class list_scoreboard;
    logic signed [DATA_W-1:0] cells[$];
    list_beat_t               owed_beats[$];
    int unsigned              errors;

    function new();
      errors = 0;
    endfunction

    function void push_beat(logic signed [DATA_W-1:0] e, status_t s, logic l);
      list_beat_t b;
      b.element = e;
      b.length  = LEN_OUT_W'(cells.size());
      b.status  = s;
      b.last    = l;
      owed_beats.push_back(b);
    endfunction

    // apply one accepted request to the list copy and queue its beats
    function void note_request(op_t o, logic signed [DATA_W-1:0] v,
                               logic [POS_W-1:0] p);
      status_t st;
      int      pos;
      st  = STAT_OK;
      pos = int'(p);
      case (o)
        OP_INS_FRONT, OP_INS_BACK: begin
          if (cells.size() >= LIST_CAP) st = STAT_FULL;
          else if (o == OP_INS_FRONT) cells.push_front(v);
          else cells.push_back(v);
        end
        OP_INS_POS: begin
          // range is checked ahead of fullness
          if (pos < 1 || pos > cells.size() + 1) st = STAT_RANGE;
          else if (cells.size() >= LIST_CAP) st = STAT_FULL;
          else cells.insert(pos - 1, v);
        end
        OP_DEL_FRONT, OP_DEL_BACK: begin
          if (cells.size() == 0) st = STAT_EMPTY;
          else if (o == OP_DEL_FRONT) void'(cells.pop_front());
          else void'(cells.pop_back());
        end
        OP_DEL_POS: begin
          // emptiness is checked ahead of the position
          if (cells.size() == 0) st = STAT_EMPTY;
          else if (pos < 1 || pos > cells.size()) st = STAT_RANGE;
          else cells.delete(pos - 1);
        end
        OP_COUNT: begin
        end
        OP_LIST: begin
          if (cells.size() == 0) begin
            push_beat('0, STAT_EMPTY, 1'b1);
          end else begin
            foreach (cells[i]) push_beat(cells[i], STAT_OK, i == cells.size() - 1);
          end
          return;
        end
        default: begin
        end
      endcase
      push_beat('0, st, 1'b1);
    endfunction

    // compare one result beat with the oldest owed beat
    function void check_result(logic signed [DATA_W-1:0] e, logic [LEN_OUT_W-1:0] len,
                               logic [STAT_W-1:0] s, logic l);
      list_beat_t b;
      if (owed_beats.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat: element %0d length %0d status %0d last %0d",
                   e, len, s, l);
        return;
      end
      b = owed_beats.pop_front();
      if (e !== b.element || len !== b.length || s !== b.status || l !== b.last) begin
        errors++;
        if (errors <= 10) begin
          $write("mismatch: expected element %0d length %0d status %0d last %0d, ",
                 b.element, b.length, b.status, b.last);
          $display("got element %0d length %0d status %0d last %0d", e, len, s, l);
        end
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     req_valid;
  logic                     req_ready;
  op_t                      op;
  logic signed [DATA_W-1:0] value;
  logic [POS_W-1:0]         position;
  logic                     rsp_valid;
  logic                     rsp_ready;
  logic signed [DATA_W-1:0] element;
  logic [LEN_OUT_W-1:0]     length;
  logic [STAT_W-1:0]        status;
  logic                     last;

  list_scoreboard sb = new();
  bit             no_idle;
  int unsigned    idle_cycles;

  positional_list_engine_top #(
    .CAPACITY (LIST_CAP)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .op        (op),
    .value     (value),
    .position  (position),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .element   (element),
    .length    (length),
    .status    (status),
    .last      (last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watch both channels and score every beat
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) sb.note_request(op, value, position);
      if (rsp_valid && rsp_ready) sb.check_result(element, length, status, last);
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // one request beat, with a random gap ahead of it
  task automatic send_request(op_t o, logic signed [DATA_W-1:0] v, logic [POS_W-1:0] p);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    op        <= o;
    value     <= v;
    position  <= p;
    do @(posedge clk); while (!(req_valid && req_ready));
  endtask

  function automatic op_t pick_op(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == MODE_GROW) begin
      if (r < 25) return OP_INS_FRONT;
      if (r < 45) return OP_INS_BACK;
      if (r < 70) return OP_INS_POS;
      if (r < 76) return OP_DEL_FRONT;
      if (r < 82) return OP_DEL_BACK;
      if (r < 88) return OP_DEL_POS;
      if (r < 94) return OP_COUNT;
      return OP_LIST;
    end
    if (mode == MODE_SHRINK) begin
      if (r < 6)  return OP_INS_FRONT;
      if (r < 12) return OP_INS_BACK;
      if (r < 18) return OP_INS_POS;
      if (r < 38) return OP_DEL_FRONT;
      if (r < 58) return OP_DEL_BACK;
      if (r < 82) return OP_DEL_POS;
      if (r < 90) return OP_COUNT;
      return OP_LIST;
    end
    return op_t'($urandom_range(0, 7));
  endfunction

  // position mostly inside the legal range, sometimes anywhere
  function automatic logic [POS_W-1:0] pick_position(op_t o, int len);
    int r;
    r = $urandom_range(0, 99);
    if (o == OP_INS_POS && r < 85) return POS_W'($urandom_range(1, len + 1));
    if (o == OP_DEL_POS && len > 0 && r < 85) return POS_W'($urandom_range(1, len));
    return POS_W'($urandom_range(0, 63));
  endfunction

  // result side ready with random stalls
  initial begin
    int stall;
    rsp_ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!(rsp_valid && rsp_ready));
    end
  end

  // reset, directed requests, random phases, drain
  initial begin
    int   sent;
    int   phase_len;
    int   mode;
    op_t  o;
    rst         = 1'b1;
    req_valid   = 1'b0;
    op          = OP_COUNT;
    value       = '0;
    position    = '0;
    no_idle     = 1'b0;
    idle_cycles = 0;
    sent        = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list corner cases
    send_request(OP_DEL_FRONT, 32'sd0, 6'd0);
    send_request(OP_DEL_BACK, 32'sd0, 6'd0);
    send_request(OP_DEL_POS, 32'sd0, 6'd1);
    send_request(OP_DEL_POS, 32'sd0, 6'd0);
    send_request(OP_LIST, 32'sd0, 6'd0);
    send_request(OP_COUNT, 32'sd0, 6'd0);
    send_request(OP_INS_POS, 32'sd7, 6'd0);
    send_request(OP_INS_POS, 32'sd7, 6'd2);
    // value extremes, position one on empty list, insert at length plus one
    send_request(OP_INS_POS, 32'sh7fffffff, 6'd1);
    send_request(OP_INS_FRONT, 32'sh80000000, 6'd0);
    send_request(OP_INS_BACK, -32'sd1, 6'd0);
    send_request(OP_INS_POS, 32'sd0, 6'd4);
    send_request(OP_INS_POS, 32'sh55555555, 6'd2);
    send_request(OP_INS_POS, 32'sd9, 6'd63);
    // delete position out of range, then delete the tail position
    send_request(OP_DEL_POS, 32'sd0, 6'd0);
    send_request(OP_DEL_POS, 32'sd0, 6'd6);
    send_request(OP_DEL_POS, 32'sd0, 6'd5);
    send_request(OP_INS_BACK, 32'shaaaaaaaa, 6'd0);
    send_request(OP_LIST, 32'sd0, 6'd0);
    send_request(OP_DEL_FRONT, 32'sd0, 6'd0);
    send_request(OP_DEL_BACK, 32'sd0, 6'd0);
    send_request(OP_DEL_POS, 32'sd0, 6'd2);
    send_request(OP_COUNT, 32'sd0, 6'd0);
    send_request(OP_LIST, 32'sd0, 6'd0);

    // random phases that fill and drain the list
    while (sent < ITEM_COUNT) begin
      phase_len = $urandom_range(20, 60);
      mode      = $urandom_range(0, 3) == 0 ? MODE_MIXED : ($urandom_range(0, 1) ? MODE_GROW
                                                                               : MODE_SHRINK);
      no_idle   = ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        if (sent >= ITEM_COUNT) break;
        o = pick_op(mode);
        send_request(o, $urandom, pick_position(o, sb.cells.size()));
        sent++;
      end
    end
    req_valid <= 1'b0;
    no_idle   = 1'b0;

    // drain owed beats, then let the block settle
    while (sb.owed_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (sb.errors == 0 && sb.owed_beats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
sv/ple_pkg.sv
sv/ple_cell.sv
sv/positional_list_engine_top.sv
sv/ple_checker.sv
tb/testbench.sv
